/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg - text console writer shared definitions
// Field widths, character codes, function codes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int FUNC_W    = 2;
    localparam int CODE_W    = 8;
    localparam int IDX_W     = 11;
    localparam int DATA_W    = 16;
    localparam int COLOR_W   = 8;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CODE_W-1:0] LOW_CODE     = 8'd20;
    localparam logic [CODE_W-1:0] HIGH_CODE    = 8'd126;
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CODE_W-1:0] SPACE_CODE   = 8'd32;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK
    } state_t;

    typedef struct packed {
        logic init_step;    // write zero at sweep address, advance sweep
        logic clear_step;   // write blank cell at sweep address, advance sweep
        logic copy_step;    // read one row down at sweep, advance sweep
        logic sweep_clr;
        logic glyph_put;    // write glyph at cursor and advance cursor
        logic newline;
        logic read_issue;
        logic out_load;
        logic out_status;
        logic out_use_mem;
    } cmd_t;

    typedef struct packed {
        logic is_newline;
        logic is_glyph;
        logic last_col;
        logic last_row;
        logic sweep_last;
        logic copy_last;
    } stat_t;

endpackage

/* src/tcw_datapath.sv */
// ----------------------------------------------------------------------------
// tcw_datapath - cell memory, cursor, sweep counter and result registers
// Executes the controller's commands: glyph writes, row advance, cell reads,
// and the one-cell-per-cycle sweeps used by init, clear and scroll.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [tcw_pkg::CODE_W-1:0]       char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
    input  logic                             text_color_we,
    input  logic [tcw_pkg::COLOR_W-1:0]      text_color,
    input  tcw_pkg::cmd_t                    cmd,
    output tcw_pkg::stat_t                   stat,
    output logic                             status,
    output logic [tcw_pkg::DATA_W-1:0]       cell_data,
    output logic [tcw_pkg::ROW_OUT_W-1:0]    cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]    cursor_col
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    logic [tcw_pkg::DATA_W-1:0]  cell_mem [CELL_COUNT];

    logic [tcw_pkg::COLOR_W-1:0] color_reg;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [ADDR_W-1:0]           row_base_reg, row_base_next;
    logic [ADDR_W-1:0]           sweep_reg, sweep_next;
    logic                        cp_wr_reg;
    logic [ADDR_W-1:0]           cp_addr_reg;
    logic                        rd_ok_reg;
    logic [tcw_pkg::DATA_W-1:0]  mem_q_reg;
    logic                        out_status_reg;
    logic [tcw_pkg::DATA_W-1:0]  out_data_reg;

    logic                        adv_row;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [tcw_pkg::DATA_W-1:0]  mem_wdata;
    logic [tcw_pkg::DATA_W-1:0]  blank_cell;
    logic                        in_range;

    assign blank_cell = {color_reg, tcw_pkg::SPACE_CODE};
    assign in_range   = 32'(cell_index) < 32'(CELL_COUNT);

    assign stat.is_newline = char_code == tcw_pkg::NEWLINE_CODE;
    assign stat.is_glyph   = (char_code >= tcw_pkg::LOW_CODE) &&
                             (char_code <= tcw_pkg::HIGH_CODE);
    assign stat.last_col   = col_reg == COL_W'(COLUMNS - 1);
    assign stat.last_row   = row_reg == ROW_W'(ROWS - 1);
    assign stat.sweep_last = sweep_reg == ADDR_W'(CELL_COUNT - 1);
    assign stat.copy_last  = sweep_reg == ADDR_W'(CELL_COUNT - COLUMNS - 1);

    // cursor update; the last row never advances, scroll keeps it there
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        adv_row       = cmd.newline || (cmd.glyph_put && stat.last_col);
        if (cmd.glyph_put && !stat.last_col)
        begin
            col_next = col_reg + 1'b1;
        end
        if (adv_row)
        begin
            col_next = '0;
            if (!stat.last_row)
            begin
                row_next      = row_reg + 1'b1;
                row_base_next = ADDR_W'(row_base_reg + COLUMNS);
            end
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_clr)
        begin
            sweep_next = '0;
        end
        else if (cmd.init_step || cmd.clear_step || cmd.copy_step)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
    end

    // single write port: sweeps, glyph write, or the delayed scroll copy
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = blank_cell;
        if (cmd.init_step)
        begin
            mem_we    = 1'b1;
            mem_wdata = '0;
        end
        else if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.glyph_put)
        begin
            mem_we    = 1'b1;
            mem_waddr = row_base_reg + ADDR_W'(col_reg);
            mem_wdata = {color_reg, char_code};
        end
        else if (cp_wr_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = cp_addr_reg;
            mem_wdata = mem_q_reg;
        end
    end

    assign mem_raddr = cmd.read_issue ? ADDR_W'(cell_index)
                                      : ADDR_W'(sweep_reg + COLUMNS);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= cell_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg    <= tcw_pkg::COLOR_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            sweep_reg    <= '0;
            cp_wr_reg    <= 1'b0;
            rd_ok_reg    <= 1'b0;
        end
        else
        begin
            if (text_color_we)
            begin
                color_reg <= text_color;
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
            sweep_reg    <= sweep_next;
            cp_wr_reg    <= cmd.copy_step;
            if (cmd.read_issue)
            begin
                rd_ok_reg <= in_range;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg <= sweep_reg;
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_data_reg   <= (cmd.out_use_mem && rd_ok_reg) ? mem_q_reg : '0;
        end
    end

    assign status     = out_status_reg;
    assign cell_data  = out_data_reg;
    assign cursor_row = tcw_pkg::ROW_OUT_W'(row_reg);
    assign cursor_col = tcw_pkg::COL_OUT_W'(col_reg);

endmodule

/* src/tcw_control.sv */
// ----------------------------------------------------------------------------
// tcw_control - text console writer sequencer
// Owns the handshakes and steps the datapath through put, read, clear,
// scroll and the post-reset init sweep.
// ----------------------------------------------------------------------------
module tcw_control (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [tcw_pkg::FUNC_W-1:0]  func,
    input  logic                        out_stall,
    input  tcw_pkg::stat_t              stat,
    output logic                        in_stall,
    output logic                        out_valid,
    output tcw_pkg::cmd_t               cmd
);

    tcw_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;
    logic            need_scroll;

    assign in_stall  = (state_reg != tcw_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // newline on the last row, or a glyph in the last cell of the screen
    assign need_scroll = stat.last_row &&
                         (stat.is_newline || (stat.is_glyph && stat.last_col));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                if (stat.sweep_last)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        tcw_pkg::FUNC_PUT:
                        begin
                            if (need_scroll)
                            begin
                                state_next = tcw_pkg::ST_COPY;
                            end
                        end
                        tcw_pkg::FUNC_READ:  state_next = tcw_pkg::ST_READ;
                        tcw_pkg::FUNC_CLEAR: state_next = tcw_pkg::ST_CLEAR;
                        default:             state_next = tcw_pkg::ST_IDLE;
                    endcase
                end
            end
            tcw_pkg::ST_READ: state_next = tcw_pkg::ST_IDLE;
            tcw_pkg::ST_CLEAR:
            begin
                if (stat.sweep_last)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_COPY:
            begin
                if (stat.copy_last)
                begin
                    state_next = tcw_pkg::ST_DRAIN;
                end
            end
            tcw_pkg::ST_DRAIN: state_next = tcw_pkg::ST_BLANK;
            tcw_pkg::ST_BLANK:
            begin
                if (stat.sweep_last)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default: state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            tcw_pkg::ST_INIT: cmd.init_step = 1'b1;
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        tcw_pkg::FUNC_PUT:
                        begin
                            if (stat.is_newline)
                            begin
                                cmd.newline = 1'b1;
                            end
                            else if (stat.is_glyph)
                            begin
                                cmd.glyph_put = 1'b1;
                            end
                            if (need_scroll)
                            begin
                                cmd.sweep_clr = 1'b1;
                            end
                            else
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = !stat.is_newline && !stat.is_glyph;
                            end
                        end
                        tcw_pkg::FUNC_READ: cmd.read_issue = 1'b1;
                        tcw_pkg::FUNC_CLEAR: cmd.sweep_clr = 1'b1;
                        default: cmd.out_load = 1'b1;
                    endcase
                end
            end
            tcw_pkg::ST_READ:
            begin
                cmd.out_load    = 1'b1;
                cmd.out_use_mem = 1'b1;
            end
            tcw_pkg::ST_CLEAR, tcw_pkg::ST_BLANK:
            begin
                cmd.clear_step = 1'b1;
                cmd.out_load   = stat.sweep_last;
            end
            tcw_pkg::ST_COPY: cmd.copy_step = 1'b1;
            default: cmd = '0;
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/text_console_writer_core.sv */
// ----------------------------------------------------------------------------
// text_console_writer_core - text-mode console engine
// Grid of 16-bit cells (color high, character low) with a cursor; handles
// put character, cell read and screen clear, scrolling past the last row.
//
//   channel  signals                          direction
//   input    in_valid/in_stall, func,         in  (stall out)
//            char_code, cell_index
//   output   out_valid/out_stall, status,     out (stall in)
//            cell_data, cursor_row, cursor_col
//   config   text_color_we, text_color        in
//
// Put and rejected codes: result registered in the cycle after transfer.
// Read: result registered after the ST_READ state. Clear: one sweep over all
// cells. Scroll (newline or wrap on the last row): copy sweep, drain, blank of
// the last row, all through the single write port of the cell memory.
// After reset the memory is zeroed one cell per cycle, in_stall high. One item
// in flight; a new one is taken in the cycle the previous result transfers.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tcw_pkg::FUNC_W-1:0]       func,
    input  logic [tcw_pkg::CODE_W-1:0]       char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             status,
    output logic [tcw_pkg::DATA_W-1:0]       cell_data,
    output logic [tcw_pkg::ROW_OUT_W-1:0]    cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]    cursor_col,
    input  logic                             text_color_we,
    input  logic [tcw_pkg::COLOR_W-1:0]      text_color
);

    tcw_pkg::cmd_t  cmd;
    tcw_pkg::stat_t stat;

    tcw_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .text_color_we (text_color_we),
        .text_color    (text_color),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .cell_data     (cell_data),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col)
    );

    // a new item only enters when the output slot is free or transferring
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid || !out_stall)
        else $error("item accepted while result still pending");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == tcw_pkg::FUNC_READ |=> !out_valid ##1 out_valid)
        else $error("read result not two cycles after transfer");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == tcw_pkg::FUNC_PUT &&
        char_code > tcw_pkg::HIGH_CODE |=> out_valid && status)
        else $error("out-of-range code not rejected");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == tcw_pkg::FUNC_CLEAR |=> in_stall && !out_valid)
        else $error("clear did not enter its sweep");

endmodule
